// ===== hw/rtl/cts_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the Cartesian-to-spherical block.
// Used by the channel interfaces and the top level; it depends on nothing else.
`default_nettype none

package cts_pkg;

  // Payload types of the two channels.
  typedef logic signed [31:0] coord_t;
  typedef logic        [31:0] length_t;
  typedef logic signed [31:0] angle_t;

  // Width of the internal datapath and of the angle accumulator.
  localparam int DATA_W         = 64;
  localparam int ANG_W          = 34;
  localparam int IN_SCALE_SHIFT = 28;
  localparam int ISQ_STEPS      = 32;
  localparam int ZK_SHIFT       = 3;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);

  // Special cases that travel with each word through the angle pipeline.
  typedef struct packed {
    logic xy_zero;
    logic z_pos;
    logic z_neg;
  } flags_t;

  // Arctangent of 2^-i as a binary angle where 2^31 is pi. Entries past 30 are zero.
  function automatic int atan_step(int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      24: return 41;
      25: return 20;
      26: return 10;
      27: return 5;
      28: return 3;
      29: return 1;
      30: return 1;
      default: return 0;
    endcase
  endfunction

  // CORDIC gain in Q31: square root of prod(1 + 4^-i) taken in Q62, truncating.
  function automatic logic [31:0] gain_q31(int steps);
    logic [63:0] g;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    g = 64'd1 << 62;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) begin
        g = g + (g >> (2 * i));
      end
    end
    n   = g;
    res = '0;
    b   = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cts_in_if.sv =====
// Input channel: one vector word with valid/ready handshake.
// Depends on cts_pkg for the coordinate type.
`default_nettype none

interface cts_in_if;
  logic            valid;
  logic            ready;
  cts_pkg::coord_t x_coord;
  cts_pkg::coord_t y_coord;
  cts_pkg::coord_t z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cts_out_if.sv =====
// Result channel: length, longitude and latitude with valid/ready handshake.
// Depends on cts_pkg for the length and angle types.
`default_nettype none

interface cts_out_if;
  logic             valid;
  logic             ready;
  cts_pkg::length_t length;
  cts_pkg::angle_t  longitude;
  cts_pkg::angle_t  latitude;

  modport source (output valid, output length, output longitude, output latitude, input ready);
  modport sink   (input valid, input length, input longitude, input latitude, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cartesian_to_spherical_top.sv =====
// Cartesian-to-spherical converter: length, longitude and latitude of a signed 3-D vector.
// Depends on cts_pkg and on the interfaces cts_in_if and cts_out_if.
//
// Usage: the in_ch channel takes one word (x, y, z) per cycle while in_ch.ready is high;
// the out_ch channel gives one word (length, longitude, latitude) for every input word, in
// order. A word is moved at a clock edge where valid and ready are both high.
// The length path is an unrolled integer square root of 32 stages; the angle path is two
// unrolled CORDIC vectoring passes of CORDIC_STEPS stages each, the second driven by the
// result of the first. The shorter path is padded.
// Throughput: one word per cycle while out_ch.ready is high.
// Stall: when the result register is full and out_ch.ready is low, the whole pipeline holds
// and in_ch.ready drops; nothing is lost or repeated.
// Reset: synchronous, active low; it clears all valid bits, so the pipeline starts empty and
// in_ch.ready is high in the first cycle after reset.
// Angles are binary angles in which 2^31 stands for pi; the length is rounded to nearest.
`default_nettype none

module cartesian_to_spherical_top #(
  parameter int CORDIC_STEPS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  cts_in_if.sink      in_ch,
  cts_out_if.source   out_ch
);

  localparam int N     = CORDIC_STEPS;
  localparam int CD    = 2 * N;
  localparam int ANG_D = CD + 1;
  localparam int LEN_D = cts_pkg::ISQ_STEPS + 3;
  localparam int D     = (ANG_D > LEN_D) ? ANG_D : LEN_D;
  localparam int DW    = cts_pkg::DATA_W;
  localparam int AW    = cts_pkg::ANG_W;
  localparam logic [31:0] GAIN = cts_pkg::gain_q31(CORDIC_STEPS);

  // Pipeline control: everything advances together unless the result word is held.
  logic adv;
  logic vld_r [0:D];

  assign adv         = !vld_r[D] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= D; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k <= D; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Input stage: raw coordinates, pre-rotation into the right half-plane and flags.
  cts_pkg::coord_t          x0_r, y0_r, z0_r;
  logic signed [DW-1:0]     cx_r [0:CD];
  logic signed [DW-1:0]     cy_r [0:CD];
  logic signed [AW-1:0]     ca_r [0:CD];
  cts_pkg::flags_t          flg_r [0:CD];

  logic signed [DW-1:0]     sx_nxt, sy_nxt, cx_nxt, cy_nxt;
  logic signed [AW-1:0]     ca_nxt;
  cts_pkg::flags_t          flg_nxt;

  always_comb begin
    sx_nxt = DW'(in_ch.x_coord) <<< cts_pkg::IN_SCALE_SHIFT;
    sy_nxt = DW'(in_ch.y_coord) <<< cts_pkg::IN_SCALE_SHIFT;
    cx_nxt = sx_nxt;
    cy_nxt = sy_nxt;
    ca_nxt = '0;
    if (in_ch.x_coord[31]) begin
      if (!in_ch.y_coord[31]) begin
        cx_nxt = sy_nxt;
        cy_nxt = -sx_nxt;
        ca_nxt = cts_pkg::QUARTER_TURN;
      end else begin
        cx_nxt = -sy_nxt;
        cy_nxt = sx_nxt;
        ca_nxt = -cts_pkg::QUARTER_TURN;
      end
    end
    flg_nxt.xy_zero = (in_ch.x_coord == '0) && (in_ch.y_coord == '0);
    flg_nxt.z_pos   = !in_ch.z_coord[31] && (in_ch.z_coord != '0);
    flg_nxt.z_neg   = in_ch.z_coord[31];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r     <= in_ch.x_coord;
      y0_r     <= in_ch.y_coord;
      z0_r     <= in_ch.z_coord;
      cx_r[0]  <= cx_nxt;
      cy_r[0]  <= cy_nxt;
      ca_r[0]  <= ca_nxt;
      flg_r[0] <= flg_nxt;
    end
  end

  // Scaled z for the second pass, formed during the first pass stage.
  logic signed [DW-1:0] zk_r [1:N];
  logic signed [DW:0]   zprod;

  assign zprod = $signed({{(DW + 1 - 32){z0_r[31]}}, z0_r})
               * $signed({{(DW + 1 - 32){1'b0}}, GAIN});

  // Longitude kept alongside the second pass.
  logic [31:0] lk_r [N+1:CD];

  // CORDIC vectoring stages: first pass in stages 1..N, second pass in N+1..2N.
  genvar k;
  generate
    for (k = 1; k <= CD; k++) begin : g_cordic
      localparam int I = (k <= N) ? (k - 1) : (k - 1 - N);
      localparam logic signed [AW-1:0] STEP = AW'(cts_pkg::atan_step(I));
      logic signed [DW-1:0] xi, yi, xs, ys;
      logic signed [AW-1:0] ai;

      if (k == N + 1) begin : g_seam
        assign xi = cx_r[N];
        assign yi = zk_r[N];
        assign ai = '0;
      end else begin : g_chain
        assign xi = cx_r[k-1];
        assign yi = cy_r[k-1];
        assign ai = ca_r[k-1];
      end

      assign xs = xi >>> I;
      assign ys = yi >>> I;

      always_ff @(posedge clk) begin
        if (adv) begin
          if (!yi[DW-1]) begin
            cx_r[k] <= xi + ys;
            cy_r[k] <= yi - xs;
            ca_r[k] <= ai + STEP;
          end else begin
            cx_r[k] <= xi - ys;
            cy_r[k] <= yi + xs;
            ca_r[k] <= ai - STEP;
          end
          flg_r[k] <= flg_r[k-1];
        end
      end

      if (k == 1) begin : g_zk_first
        always_ff @(posedge clk) begin
          if (adv) begin
            zk_r[k] <= DW'(zprod >>> cts_pkg::ZK_SHIFT);
          end
        end
      end else if (k <= N) begin : g_zk_carry
        always_ff @(posedge clk) begin
          if (adv) begin
            zk_r[k] <= zk_r[k-1];
          end
        end
      end else if (k == N + 1) begin : g_lon_first
        always_ff @(posedge clk) begin
          if (adv) begin
            lk_r[k] <= ca_r[N][31:0];
          end
        end
      end else begin : g_lon_carry
        always_ff @(posedge clk) begin
          if (adv) begin
            lk_r[k] <= lk_r[k-1];
          end
        end
      end
    end
  endgenerate

  // Angle output stage: special cases and latitude saturation, then padding.
  logic [31:0]          lon_d_r [ANG_D:D];
  logic [31:0]          lat_d_r [ANG_D:D];
  logic [31:0]          lon_nxt, lat_nxt;
  logic signed [AW-1:0] lat_sat;

  always_comb begin
    lat_sat = ca_r[CD];
    if (lat_sat > cts_pkg::QUARTER_TURN) begin
      lat_sat = cts_pkg::QUARTER_TURN;
    end else if (lat_sat < -cts_pkg::QUARTER_TURN) begin
      lat_sat = -cts_pkg::QUARTER_TURN;
    end
    if (flg_r[CD].xy_zero) begin
      lon_nxt = '0;
      if (flg_r[CD].z_pos) begin
        lat_nxt = cts_pkg::QUARTER_TURN[31:0];
      end else if (flg_r[CD].z_neg) begin
        lat_nxt = 32'(-cts_pkg::QUARTER_TURN);
      end else begin
        lat_nxt = '0;
      end
    end else begin
      lon_nxt = lk_r[CD];
      lat_nxt = lat_sat[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lon_d_r[ANG_D] <= lon_nxt;
      lat_d_r[ANG_D] <= lat_nxt;
      for (int p = ANG_D + 1; p <= D; p++) begin
        lon_d_r[p] <= lon_d_r[p-1];
        lat_d_r[p] <= lat_d_r[p-1];
      end
    end
  end

  // Length path: squares, their sum, then one square-root bit per stage.
  logic [DW-1:0] sqx_r, sqy_r, sqz_r, sum_r;
  logic [DW-1:0] qn_r [1:cts_pkg::ISQ_STEPS];
  logic [DW-1:0] qr_r [1:cts_pkg::ISQ_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= DW'(DW'(x0_r) * DW'(x0_r));
      sqy_r <= DW'(DW'(y0_r) * DW'(y0_r));
      sqz_r <= DW'(DW'(z0_r) * DW'(z0_r));
      sum_r <= sqx_r + sqy_r + sqz_r;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= cts_pkg::ISQ_STEPS; j++) begin : g_isq
      localparam logic [DW-1:0] BIT = DW'(64'd1 << (62 - 2 * (j - 1)));
      logic [DW-1:0] n_in, r_in, t;

      if (j == 1) begin : g_head
        assign n_in = sum_r;
        assign r_in = '0;
      end else begin : g_body
        assign n_in = qn_r[j-1];
        assign r_in = qr_r[j-1];
      end

      assign t = r_in + BIT;

      always_ff @(posedge clk) begin
        if (adv) begin
          if (n_in >= t) begin
            qn_r[j] <= n_in - t;
            qr_r[j] <= (r_in >> 1) + BIT;
          end else begin
            qn_r[j] <= n_in;
            qr_r[j] <= r_in >> 1;
          end
        end
      end
    end
  endgenerate

  // Round to nearest and pad the length to the common depth.
  logic [31:0] len_d_r [LEN_D:D];

  always_ff @(posedge clk) begin
    if (adv) begin
      len_d_r[LEN_D] <= 32'(qr_r[cts_pkg::ISQ_STEPS]
                       + DW'(qn_r[cts_pkg::ISQ_STEPS] > qr_r[cts_pkg::ISQ_STEPS]));
      for (int p = LEN_D + 1; p <= D; p++) begin
        len_d_r[p] <= len_d_r[p-1];
      end
    end
  end

  // Result word.
  assign out_ch.valid     = vld_r[D];
  assign out_ch.length    = len_d_r[D];
  assign out_ch.longitude = lon_d_r[D];
  assign out_ch.latitude  = lat_d_r[D];

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Cartesian-to-spherical converter.
// Depends on cts_pkg, cts_in_if, cts_out_if and cartesian_to_spherical_top.
`default_nettype none

module tb_top;

  localparam int STEPS      = 32;
  localparam int LATENCY    = 65;
  localparam int N_DIRECTED = 18;
  localparam int N_RANDOM   = 1930;
  localparam int N_ITEMS    = N_DIRECTED + N_RANDOM;
  localparam int LAST_CALM  = 300;
  localparam int LONG_HOLD  = 150;

  typedef struct packed {
    cts_pkg::coord_t x;
    cts_pkg::coord_t y;
    cts_pkg::coord_t z;
  } vec_t;

  typedef struct packed {
    cts_pkg::length_t len;
    cts_pkg::angle_t  lon;
    cts_pkg::angle_t  lat;
  } sph_t;

  logic clk;
  logic rst_n;

  cts_in_if  in_ch ();
  cts_out_if out_ch ();

  cartesian_to_spherical_top #(.CORDIC_STEPS(STEPS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vec_t   vec_q[$];
  sph_t   sph_q[$];
  int     n_mismatch;
  int     n_sent;
  int     n_total;
  bit     stim_done;
  bit     in_acc;
  int     src_idle;
  int     sink_hold_cycles;
  bit     long_go;
  bit     long_seen;
  int     long_hold;
  logic [63:0] k_gain;

  // Clock with a period of 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor square root of a 64-bit value, with remainder.
  function automatic logic [63:0] sqrt_floor(logic [63:0] n, output logic [63:0] rem);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    rem = n;
    return res;
  endfunction

  // One CORDIC vectoring pass; drives y toward zero and returns the angle.
  function automatic longint rotate_out(inout longint x, inout longint y, input longint a);
    longint xs;
    longint ys;
    longint st;
    for (int i = 0; i < STEPS; i++) begin
      st = (i < 40) ? longint'(atan_tab(i)) : 0;
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; a = a + st;
      end else begin
        x = x - ys; y = y + xs; a = a - st;
      end
    end
    return a;
  endfunction

  function automatic int atan_tab(int i);
    int t[40] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                  10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                  83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                  81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    return t[i];
  endfunction

  // Expected length, longitude and latitude of one vector.
  function automatic sph_t spherical_of(vec_t v);
    longint x;
    longint y;
    longint z;
    longint cx;
    longint cy;
    longint t;
    longint a;
    longint lon;
    longint lat;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] rem;
    sph_t o;
    x = longint'($signed(v.x));
    y = longint'($signed(v.y));
    z = longint'($signed(v.z));
    lon = 0; lat = 0;
    s = 64'(x * x) + 64'(y * y) + 64'(z * z);
    r = sqrt_floor(s, rem);
    if (rem > r) r = r + 1;
    if (x != 0 || y != 0) begin
      a  = 0;
      cx = x <<< cts_pkg::IN_SCALE_SHIFT;
      cy = y <<< cts_pkg::IN_SCALE_SHIFT;
      if (cx < 0) begin
        t = cx;
        if (cy >= 0) begin
          cx = cy; cy = -t; a = 64'sd1073741824;
        end else begin
          cx = -cy; cy = t; a = -64'sd1073741824;
        end
      end
      lon = rotate_out(cx, cy, a);
      cy  = (z * longint'(k_gain)) >>> cts_pkg::ZK_SHIFT;
      lat = rotate_out(cx, cy, 0);
    end else if (z > 0) begin
      lat = 64'sd1073741824;
    end else if (z < 0) begin
      lat = -64'sd1073741824;
    end
    if (lat > 64'sd1073741824) lat = 64'sd1073741824;
    if (lat < -64'sd1073741824) lat = -64'sd1073741824;
    o.len = r[31:0];
    o.lon = lon[31:0];
    o.lat = lat[31:0];
    return o;
  endfunction

  // Gain of the CORDIC passes in Q31.
  function automatic logic [63:0] gain_of_steps();
    logic [63:0] g;
    logic [63:0] rem;
    g = 64'd1 << 62;
    for (int i = 0; i < STEPS; i++) begin
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    return sqrt_floor(g, rem);
  endfunction

  function automatic cts_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return cts_pkg::coord_t'($urandom_range(0, 16)) - 8;
      1: return cts_pkg::coord_t'($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return cts_pkg::coord_t'($urandom());
    endcase
  endfunction

  // Input acceptance, sampled at the rising edge.
  always @(posedge clk) begin
    in_acc <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Driver: offers the next pending word, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_idle    <= 0;
      n_sent      <= 0;
    end else begin
      if (in_acc) begin
        void'(vec_q.pop_front());
        n_sent <= n_sent + 1;
      end
      if (in_ch.valid && !in_acc) begin
        // The offered word waits until it is taken.
      end else if (src_idle > 0) begin
        src_idle    <= src_idle - 1;
        in_ch.valid <= 1'b0;
      end else if (vec_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (n_sent < N_ITEMS - LAST_CALM && $urandom_range(0, 15) == 0) begin
        src_idle    <= int'($urandom_range(1, 8)) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.x_coord <= vec_q[0].x;
        in_ch.y_coord <= vec_q[0].y;
        in_ch.z_coord <= vec_q[0].z;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
      long_seen <= 1'b0;
    end else if (long_go && !long_seen) begin
      long_hold <= LONG_HOLD;
      long_seen <= 1'b1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // Receiver backpressure in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready     <= 1'b0;
      sink_hold_cycles <= 0;
    end else if (long_hold > 0) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold_cycles > 0) begin
      sink_hold_cycles <= sink_hold_cycles - 1;
      out_ch.ready     <= 1'b0;
    end else if (stim_done || n_sent >= N_ITEMS - LAST_CALM) begin
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      sink_hold_cycles <= int'($urandom_range(1, 8)) - 1;
      out_ch.ready     <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sph_q.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10) $display("unexpected result word");
      end else begin
        if (out_ch.length !== sph_q[0].len || out_ch.longitude !== sph_q[0].lon ||
            out_ch.latitude !== sph_q[0].lat) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) begin
            $display("mismatch: exp len %0d lon %0d lat %0d, got len %0d lon %0d lat %0d",
                     sph_q[0].len, sph_q[0].lon, sph_q[0].lat,
                     out_ch.length, out_ch.longitude, out_ch.latitude);
          end
        end
        void'(sph_q.pop_front());
      end
    end
  end

  task automatic push_vec(cts_pkg::coord_t x, cts_pkg::coord_t y, cts_pkg::coord_t z);
    vec_t v;
    v = '{x: x, y: y, z: z};
    vec_q.push_back(v);
    sph_q.push_back(spherical_of(v));
    n_total++;
  endtask

  // Stimulus and end of run.
  initial begin
    rst_n         = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_coord = '0;
    n_mismatch = 0; n_total = 0; stim_done = 0; long_go = 0;
    k_gain = gain_of_steps();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero vector, axes, extremes, negative x axis.
    push_vec(0, 0, 0);
    push_vec(0, 0, 5);
    push_vec(0, 0, -5);
    push_vec(0, 0, 32'sh80000000);
    push_vec(7, 0, 0);
    push_vec(-7, 0, 0);
    push_vec(0, 9, 0);
    push_vec(0, -9, 0);
    push_vec(-3, -1, 2);
    push_vec(-3, 1, -2);
    push_vec(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_vec(32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_vec(32'sh80000000, 0, 0);
    push_vec(32'sh80000000, -1, 32'sh7fffffff);
    push_vec(1, 1, 1);
    push_vec(-1, -1, -1);
    push_vec(32'sh7fffffff, 32'sh80000000, 0);
    push_vec(1, 0, 32'sh7fffffff);
    wait (vec_q.size() == 0);

    // Long receiver hold-off while the sender keeps offering words.
    for (int i = 0; i < 200; i++) push_vec(rand_coord(), rand_coord(), rand_coord());
    long_go = 1;
    wait (vec_q.size() == 0);

    // Sender pause until the pipeline drains.
    wait (sph_q.size() == 0);
    for (int i = 0; i < N_RANDOM - 200; i++) push_vec(rand_coord(), rand_coord(), rand_coord());
    wait (vec_q.size() == 0);
    stim_done = 1;
    wait (sph_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_mismatch == 0 && sph_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
